// File: rtl/core/spa_pkg.sv
`timescale 1ns / 1ps
package spa_pkg;

   localparam int COEF_W = 32;
   localparam int EXP_W  = 31;

   // operation codes carried in req_tuser
   localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
   localparam logic [1:0] OP_ADD         = 2'd2;

   typedef struct packed {
      logic wr;
      logic clr;
   } spa_list_ctl_type;

endpackage

// File: rtl/core/spa_list.sv
`timescale 1ns / 1ps
module spa_list
   import spa_pkg::*;
#(
   parameter int TERMS_PER_LIST = 16,
   parameter int CNT_W = $clog2(TERMS_PER_LIST + 1),
   parameter int IDX_W = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spa_list_ctl_type         ctl,
   input  logic signed [COEF_W-1:0] wr_coef,
   input  logic [EXP_W-1:0]         wr_exp,
   input  logic [IDX_W-1:0]         rd_idx,
   output logic signed [COEF_W-1:0] rd_coef,
   output logic [EXP_W-1:0]         rd_exp,
   output logic [CNT_W-1:0]         count
);

   localparam logic [CNT_W-1:0] FULL = CNT_W'(TERMS_PER_LIST);

   logic signed [COEF_W-1:0] coef_ff [TERMS_PER_LIST];
   logic [EXP_W-1:0]         exp_ff  [TERMS_PER_LIST];
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     wr_ok;

   assign wr_ok = ctl.wr && (count_ff < FULL);

   always_comb begin
      count_in = count_ff;
      if (ctl.clr) begin
         count_in = '0;
      end else if (wr_ok) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // terms land at the fill position; a full list drops the beat
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         coef_ff[count_ff[IDX_W-1:0]] <= wr_coef;
         exp_ff[count_ff[IDX_W-1:0]]  <= wr_exp;
      end
   end

   assign rd_coef = coef_ff[rd_idx];
   assign rd_exp  = exp_ff[rd_idx];
   assign count   = count_ff;

endmodule

// File: rtl/core/spa_merge.sv
`timescale 1ns / 1ps
module spa_merge
   import spa_pkg::*;
#(
   parameter int TERMS_PER_LIST = 16,
   parameter int CNT_W = $clog2(TERMS_PER_LIST + 1),
   parameter int IDX_W = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [1:0]               op,
   input  logic [CNT_W-1:0]         count_a,
   input  logic [CNT_W-1:0]         count_b,
   output spa_list_ctl_type         ctl_a,
   output spa_list_ctl_type         ctl_b,
   output logic [IDX_W-1:0]         idx_a,
   output logic [IDX_W-1:0]         idx_b,
   input  logic signed [COEF_W-1:0] a_coef,
   input  logic [EXP_W-1:0]         a_exp,
   input  logic signed [COEF_W-1:0] b_coef,
   input  logic [EXP_W-1:0]         b_exp,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic signed [COEF_W-1:0] rsp_coef,
   output logic [EXP_W-1:0]         rsp_exp,
   output logic                     rsp_empty,
   output logic                     rsp_last
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MERGE = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [CNT_W-1:0]         a_ff, a_in, b_ff, b_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic signed [COEF_W-1:0] pend_coef_ff, pend_coef_in;
   logic [EXP_W-1:0]         pend_exp_ff, pend_exp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [COEF_W-1:0] rsp_coef_ff, rsp_coef_in;
   logic [EXP_W-1:0]         rsp_exp_ff, rsp_exp_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     out_free, push, req_beat;
   logic                     a_left, b_left, exp_gt, exp_eq;
   logic                     take_a, take_b, take_both, produce;
   logic signed [COEF_W-1:0] sum, term_coef;
   logic [EXP_W-1:0]         term_exp;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign idx_a = a_ff[IDX_W-1:0];
   assign idx_b = b_ff[IDX_W-1:0];

   // shared compare / add unit, one merge step per cycle while the rsp register is free
   assign a_left    = a_ff < count_a;
   assign b_left    = b_ff < count_b;
   assign exp_gt    = a_exp > b_exp;
   assign exp_eq    = a_exp == b_exp;
   assign sum       = a_coef + b_coef;
   assign take_both = a_left && b_left && exp_eq;
   assign take_a    = a_left && (!b_left || exp_gt);
   assign take_b    = b_left && (!a_left || (!exp_gt && !exp_eq));
   assign produce   = take_a || take_b || (take_both && (sum != '0));
   assign term_coef = take_both ? sum : (take_a ? a_coef : b_coef);
   assign term_exp  = take_b ? b_exp : a_exp;

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      pend_valid_in = pend_valid_ff;
      pend_coef_in  = pend_coef_ff;
      pend_exp_in   = pend_exp_ff;
      rsp_coef_in   = rsp_coef_ff;
      rsp_exp_in    = rsp_exp_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_last_in   = rsp_last_ff;
      push          = 1'b0;
      ctl_a         = '0;
      ctl_b         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               case (op)
                  OP_LOAD_FIRST:  ctl_a.wr = 1'b1;
                  OP_LOAD_SECOND: ctl_b.wr = 1'b1;
                  OP_ADD: begin
                     a_in     = '0;
                     b_in     = '0;
                     state_in = ST_MERGE;
                  end
                  default: ;
               endcase
            end
         end
         ST_MERGE: begin
            if (out_free) begin
               if (!a_left && !b_left) begin
                  state_in = ST_FLUSH;
               end else begin
                  a_in = a_ff + CNT_W'(take_a || take_both);
                  b_in = b_ff + CNT_W'(take_b || take_both);
                  // hold one term back so the final one can carry tlast
                  if (produce) begin
                     if (pend_valid_ff) begin
                        push         = 1'b1;
                        rsp_coef_in  = pend_coef_ff;
                        rsp_exp_in   = pend_exp_ff;
                        rsp_empty_in = 1'b0;
                        rsp_last_in  = 1'b0;
                     end
                     pend_valid_in = 1'b1;
                     pend_coef_in  = term_coef;
                     pend_exp_in   = term_exp;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               push        = 1'b1;
               rsp_last_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_coef_in  = pend_coef_ff;
                  rsp_exp_in   = pend_exp_ff;
                  rsp_empty_in = 1'b0;
               end else begin
                  rsp_coef_in  = '0;
                  rsp_exp_in   = '0;
                  rsp_empty_in = 1'b1;
               end
               pend_valid_in = 1'b0;
               ctl_a.clr     = 1'b1;
               ctl_b.clr     = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = push ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         a_ff          <= '0;
         b_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         a_ff          <= a_in;
         b_ff          <= b_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_coef_ff <= pend_coef_in;
      pend_exp_ff  <= pend_exp_in;
      rsp_coef_ff  <= rsp_coef_in;
      rsp_exp_ff   <= rsp_exp_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_coef   = rsp_coef_ff;
   assign rsp_exp    = rsp_exp_ff;
   assign rsp_empty  = rsp_empty_ff;
   assign rsp_last   = rsp_last_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |-> (a_ff <= count_a) && (b_ff <= count_b))
      else $error("merge index ran past list count");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_last_ff)
      else $error("empty result beat without tlast");

   a_flush_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH && out_free |=> state_ff == ST_IDLE && !pend_valid_ff)
      else $error("flush did not return to idle");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("held term left over in idle");

endmodule

// File: rtl/core/sparse_polynomial_add_top.sv
`timescale 1ns / 1ps
// channel  dir  ports          payload
// req      in   req_t*         tuser: operation[1:0]; tdata: coef, exp, pad
// rsp      out  rsp_t*         tuser: empty_res; tdata: out_coef, out_exp, pad;
//                              tlast: last
//
// A load beat is written without leaving idle. An add runs one merge step
// per cycle through the single compare/add unit while rsp is not stalled,
// then a flush step issues the final beat; req_tready is low meanwhile.
// Reset clears both list counts and all handshake state; list contents are
// not cleared. A stalled rsp beat freezes the merge until it is taken.
module sparse_polynomial_add_top
   import spa_pkg::*;
#(
   parameter int TERMS_PER_LIST = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // coef[31:0], exp[62:32], zero [63]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_coef[31:0], out_exp[62:32], zero [63]
   output logic        rsp_tuser,   // empty_res
   output logic        rsp_tlast
);

   localparam int CNT_W = $clog2(TERMS_PER_LIST + 1);
   localparam int IDX_W = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1;

   spa_list_ctl_type         ctl_a, ctl_b;
   logic [IDX_W-1:0]         idx_a, idx_b;
   logic signed [COEF_W-1:0] a_coef, b_coef, rsp_coef;
   logic [EXP_W-1:0]         a_exp, b_exp, rsp_exp;
   logic [CNT_W-1:0]         count_a, count_b;
   logic signed [COEF_W-1:0] req_coef;
   logic [EXP_W-1:0]         req_exp;

   assign req_coef = req_tdata[COEF_W-1:0];
   assign req_exp  = req_tdata[COEF_W+EXP_W-1:COEF_W];

   spa_list #(
      .TERMS_PER_LIST(TERMS_PER_LIST)
   ) u_list_a (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl_a),
      .wr_coef (req_coef),
      .wr_exp  (req_exp),
      .rd_idx  (idx_a),
      .rd_coef (a_coef),
      .rd_exp  (a_exp),
      .count   (count_a)
   );

   spa_list #(
      .TERMS_PER_LIST(TERMS_PER_LIST)
   ) u_list_b (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl_b),
      .wr_coef (req_coef),
      .wr_exp  (req_exp),
      .rd_idx  (idx_b),
      .rd_coef (b_coef),
      .rd_exp  (b_exp),
      .count   (count_b)
   );

   spa_merge #(
      .TERMS_PER_LIST(TERMS_PER_LIST)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .op         (req_tuser),
      .count_a    (count_a),
      .count_b    (count_b),
      .ctl_a      (ctl_a),
      .ctl_b      (ctl_b),
      .idx_a      (idx_a),
      .idx_b      (idx_b),
      .a_coef     (a_coef),
      .a_exp      (a_exp),
      .b_coef     (b_coef),
      .b_exp      (b_exp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_coef   (rsp_coef),
      .rsp_exp    (rsp_exp),
      .rsp_empty  (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_exp, rsp_coef};

endmodule
